// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, sampled on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TPP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define TPP_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define TPP_ASSERT(lbl, prop, msg)
`define TPP_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

// ===== rtl/tpp_pkg.sv =====
// ---------------------------------------------------------------------------
// tpp_pkg
// Shared types and constants of the target packet parser.
// ---------------------------------------------------------------------------
package tpp_pkg;

  localparam int MAX_PACKET_LEN_DEF = 16;
  localparam int DATA_W             = 16;
  localparam int FIFO_DEPTH         = 2;

  localparam logic [7:0] CH_START = 8'h40;
  localparam logic [7:0] CH_END   = 8'h23;
  localparam logic [7:0] CH_SEP   = 8'h2C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [1:0] CFG_CENTER_X = 2'd0;
  localparam logic [1:0] CFG_CENTER_Y = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT  = 2'd2;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic CAUSE_PACKET  = 1'b0;
  localparam logic CAUSE_OFFLINE = 1'b1;

  typedef enum logic [2:0] {
    PH_FLAG  = 3'd0,
    PH_SEP   = 3'd1,
    PH_X0    = 3'd2,
    PH_X     = 3'd3,
    PH_Y0    = 3'd4,
    PH_Y     = 3'd5
  } phase_t;

  typedef struct packed {
    logic              cause;
    logic              flag;
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] y;
  } evt_t;

endpackage

// ===== rtl/tpp_if.sv =====
// ---------------------------------------------------------------------------
// tpp_in_if / tpp_out_if
// Valid/ready channels for input words and result words.
// ---------------------------------------------------------------------------
interface tpp_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] rx_byte;
  modport source (output valid, opcode, rx_byte, input ready);
  modport sink   (input valid, opcode, rx_byte, output ready);
endinterface

interface tpp_out_if;
  logic               valid;
  logic               ready;
  logic               cause;
  logic               target_valid;
  logic [15:0]        target_x;
  logic [15:0]        target_y;
  logic signed [15:0] offset_x;
  logic signed [15:0] offset_y;
  modport source (output valid, cause, target_valid, target_x, target_y, offset_x, offset_y,
                  input ready);
  modport sink   (input valid, cause, target_valid, target_x, target_y, offset_x, offset_y,
                  output ready);
endinterface

// ===== rtl/target_packet_parser.sv =====
// ---------------------------------------------------------------------------
// target_packet_parser
// Parses '@v,x,y#' target packets and watches the link for silence.
// ---------------------------------------------------------------------------
// Input channel in_ch carries one word per handshake: opcode 0 with a
// received byte in rx_byte, or opcode 1 for a one millisecond tick.
// Output channel out_ch carries one result word for each well-formed
// packet (cause 0) or each link timeout (cause 1, all target fields zero).
// Configuration: cfg_we writes cfg_wdata into center_x, center_y or
// timeout_ticks, selected by cfg_index; write only while idle.
// Throughput: one input word per cycle while the event queue is not full; the
// parse state, accumulators and timeout counter all update in the cycle the word is accepted.
// Path: with the queue empty, the event is written into the event queue at
// the edge that accepts the causing word and then moves into the output
// register, which drives out_ch.valid.
// Stall: the queue absorbs two events while out_ch is held; in_ch.ready
// drops only when the queue is full.
// Reset: parser offline and idle, centre 200/120, timeout 150 ticks.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module target_packet_parser
  import tpp_pkg::*;
#(
  parameter int MAX_PACKET_LEN = MAX_PACKET_LEN_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  tpp_in_if.sink            in_ch,
  tpp_out_if.source         out_ch,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [DATA_W-1:0] cfg_wdata
);

  logic [DATA_W-1:0] center_x_r, center_y_r, timeout_r;
  logic              evt_valid, evt_ready, evt_avail, evt_pop;
  evt_t              evt_in, evt_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= DATA_W'(200);
      center_y_r <= DATA_W'(120);
      timeout_r  <= DATA_W'(150);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CENTER_X: center_x_r <= cfg_wdata;
        CFG_CENTER_Y: center_y_r <= cfg_wdata;
        CFG_TIMEOUT:  timeout_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  tpp_front #(.MAX_PACKET_LEN(MAX_PACKET_LEN)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .timeout_ticks (timeout_r),
    .evt_ready     (evt_ready),
    .evt_valid     (evt_valid),
    .evt           (evt_in)
  );

  tpp_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (evt_valid),
    .push_evt  (evt_in),
    .not_full  (evt_ready),
    .pop       (evt_pop),
    .not_empty (evt_avail),
    .head      (evt_head)
  );

  tpp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .evt_avail (evt_avail),
    .evt       (evt_head),
    .evt_pop   (evt_pop),
    .center_x  (center_x_r),
    .center_y  (center_y_r),
    .out_ch    (out_ch)
  );

  `TPP_ASSERT(a_offline_zero,
    out_ch.valid && out_ch.cause |-> out_ch.target_valid == 1'b0 &&
    out_ch.target_x == '0 && out_ch.offset_x == '0 && out_ch.offset_y == '0,
    "offline word carries target data")
  `TPP_ASSERT(a_offset_x,
    out_ch.valid && !out_ch.cause |->
    out_ch.offset_x == signed'(DATA_W'(out_ch.target_x - center_x_r)),
    "offset_x does not match centre")
  `TPP_ASSERT_NEVER(a_tick_no_packet,
    in_ch.valid && in_ch.ready && in_ch.opcode && evt_valid && !evt_in.cause,
    "tick produced a packet event")
  `TPP_ASSERT_NEVER(a_byte_no_offline,
    in_ch.valid && in_ch.ready && !in_ch.opcode && evt_valid && evt_in.cause,
    "byte produced an offline event")

endmodule

// ===== rtl/tpp_front.sv =====
// ---------------------------------------------------------------------------
// tpp_front
// Accepts bytes and ticks, checks packet grammar and link timeout, and
// raises at most one event per word.
// ---------------------------------------------------------------------------
module tpp_front
  import tpp_pkg::*;
#(
  parameter int MAX_PACKET_LEN = MAX_PACKET_LEN_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  tpp_in_if.sink            in_ch,
  input  logic [DATA_W-1:0] timeout_ticks,
  input  logic              evt_ready,
  output logic              evt_valid,
  output evt_t              evt
);

  localparam int CW = $clog2(MAX_PACKET_LEN);
  localparam logic [CW-1:0] CNT_LIMIT = CW'(MAX_PACKET_LEN - 1);
  localparam logic [DATA_W-1:0] EL_MAX = {DATA_W{1'b1}};

  logic              receiving_r, receiving_nxt;
  logic [CW-1:0]     char_count_r, char_count_nxt;
  phase_t            phase_r, phase_nxt;
  logic              grammar_ok_r, grammar_ok_nxt;
  logic              flag_r, flag_nxt;
  logic [DATA_W-1:0] acc_x_r, acc_x_nxt;
  logic [DATA_W-1:0] acc_y_r, acc_y_nxt;
  logic              online_r, online_nxt;
  logic [DATA_W-1:0] elapsed_r, elapsed_nxt;

  logic              accept;
  logic              is_byte;
  logic              is_digit;
  logic              overflow;
  logic [DATA_W-1:0] el_inc;
  logic [DATA_W-1:0] digit;
  logic [DATA_W-1:0] acc_x_dig;
  logic [DATA_W-1:0] acc_y_dig;

  assign in_ch.ready = evt_ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_byte     = (in_ch.opcode == OP_BYTE);
  assign is_digit    = (in_ch.rx_byte >= CH_ZERO) && (in_ch.rx_byte <= CH_NINE);
  assign overflow    = (char_count_r >= CNT_LIMIT);
  assign el_inc      = (elapsed_r == EL_MAX) ? elapsed_r : elapsed_r + 1'b1;
  assign digit       = DATA_W'(4'(in_ch.rx_byte - CH_ZERO));
  assign acc_x_dig   = (acc_x_r << 3) + (acc_x_r << 1) + digit;
  assign acc_y_dig   = (acc_y_r << 3) + (acc_y_r << 1) + digit;

  // next state
  always_comb begin
    receiving_nxt  = receiving_r;
    char_count_nxt = char_count_r;
    phase_nxt      = phase_r;
    grammar_ok_nxt = grammar_ok_r;
    flag_nxt       = flag_r;
    acc_x_nxt      = acc_x_r;
    acc_y_nxt      = acc_y_r;
    online_nxt     = online_r;
    elapsed_nxt    = elapsed_r;
    if (accept && is_byte) begin
      online_nxt  = 1'b1;
      elapsed_nxt = '0;
      if (in_ch.rx_byte == CH_START) begin
        receiving_nxt  = 1'b1;
        char_count_nxt = CW'(1);
        phase_nxt      = PH_FLAG;
        grammar_ok_nxt = 1'b1;
        flag_nxt       = 1'b0;
        acc_x_nxt      = '0;
        acc_y_nxt      = '0;
      end else if (receiving_r) begin
        if (overflow || in_ch.rx_byte == CH_END) begin
          receiving_nxt  = 1'b0;
          char_count_nxt = '0;
        end else begin
          char_count_nxt = char_count_r + 1'b1;
          if (grammar_ok_r) begin
            case (phase_r)
              PH_FLAG: begin
                if (in_ch.rx_byte == CH_ZERO || in_ch.rx_byte == CH_ONE) begin
                  flag_nxt  = in_ch.rx_byte[0];
                  phase_nxt = PH_SEP;
                end else begin
                  grammar_ok_nxt = 1'b0;
                end
              end
              PH_SEP: begin
                if (in_ch.rx_byte == CH_SEP) phase_nxt = PH_X0;
                else grammar_ok_nxt = 1'b0;
              end
              PH_X0, PH_X: begin
                if (is_digit) begin
                  acc_x_nxt = acc_x_dig;
                  phase_nxt = PH_X;
                end else if (phase_r == PH_X && in_ch.rx_byte == CH_SEP) begin
                  phase_nxt = PH_Y0;
                end else begin
                  grammar_ok_nxt = 1'b0;
                end
              end
              PH_Y0, PH_Y: begin
                if (is_digit) begin
                  acc_y_nxt = acc_y_dig;
                  phase_nxt = PH_Y;
                end else begin
                  grammar_ok_nxt = 1'b0;
                end
              end
              default: grammar_ok_nxt = 1'b0;
            endcase
          end
        end
      end
    end else if (accept) begin
      elapsed_nxt = el_inc;
      if (online_r && el_inc > timeout_ticks) begin
        online_nxt     = 1'b0;
        receiving_nxt  = 1'b0;
        char_count_nxt = '0;
      end
    end
  end

  // event outputs
  always_comb begin
    evt_valid = 1'b0;
    evt       = '0;
    if (accept && is_byte) begin
      if (in_ch.rx_byte == CH_END && receiving_r && !overflow &&
          grammar_ok_r && phase_r == PH_Y) begin
        evt_valid = 1'b1;
        evt.cause = CAUSE_PACKET;
        evt.flag  = flag_r;
        evt.x     = acc_x_r;
        evt.y     = acc_y_r;
      end
    end else if (accept) begin
      if (online_r && el_inc > timeout_ticks) begin
        evt_valid = 1'b1;
        evt.cause = CAUSE_OFFLINE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      receiving_r  <= 1'b0;
      char_count_r <= '0;
      phase_r      <= PH_FLAG;
      grammar_ok_r <= 1'b0;
      flag_r       <= 1'b0;
      acc_x_r      <= '0;
      acc_y_r      <= '0;
      online_r     <= 1'b0;
      elapsed_r    <= '0;
    end else begin
      receiving_r  <= receiving_nxt;
      char_count_r <= char_count_nxt;
      phase_r      <= phase_nxt;
      grammar_ok_r <= grammar_ok_nxt;
      flag_r       <= flag_nxt;
      acc_x_r      <= acc_x_nxt;
      acc_y_r      <= acc_y_nxt;
      online_r     <= online_nxt;
      elapsed_r    <= elapsed_nxt;
    end
  end

endmodule

// ===== rtl/tpp_fifo.sv =====
// ---------------------------------------------------------------------------
// tpp_fifo
// Short event queue between the front and back ends.
// ---------------------------------------------------------------------------
module tpp_fifo
  import tpp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  evt_t push_evt,
  output logic not_full,
  input  logic pop,
  output logic not_empty,
  output evt_t head
);

  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  evt_t          mem_r [FIFO_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign not_full  = (count_r != CW'(FIFO_DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;
  assign head      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_evt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (do_push && !do_pop)      count_r <= count_r + 1'b1;
      else if (do_pop && !do_push) count_r <= count_r - 1'b1;
    end
  end

endmodule

// ===== rtl/tpp_back.sv =====
// ---------------------------------------------------------------------------
// tpp_back
// Takes queued events, forms offsets from the centre and holds the result
// word in the output register.
// ---------------------------------------------------------------------------
module tpp_back
  import tpp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              evt_avail,
  input  evt_t              evt,
  output logic              evt_pop,
  input  logic [DATA_W-1:0] center_x,
  input  logic [DATA_W-1:0] center_y,
  tpp_out_if.source         out_ch
);

  logic              out_v_r;
  logic              cause_r, flag_r;
  logic [DATA_W-1:0] x_r, y_r, ox_r, oy_r;
  logic [DATA_W-1:0] ox_nxt, oy_nxt;

  assign evt_pop = evt_avail && (!out_v_r || out_ch.ready);
  assign ox_nxt  = (evt.cause == CAUSE_OFFLINE) ? '0 : evt.x - center_x;
  assign oy_nxt  = (evt.cause == CAUSE_OFFLINE) ? '0 : evt.y - center_y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (evt_pop) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (evt_pop) begin
      cause_r <= evt.cause;
      flag_r  <= evt.flag;
      x_r     <= evt.x;
      y_r     <= evt.y;
      ox_r    <= ox_nxt;
      oy_r    <= oy_nxt;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.cause        = cause_r;
  assign out_ch.target_valid = flag_r;
  assign out_ch.target_x     = x_r;
  assign out_ch.target_y     = y_r;
  assign out_ch.offset_x     = signed'(ox_r);
  assign out_ch.offset_y     = signed'(oy_r);

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb - target packet parser testbench
// Drives received bytes and millisecond ticks into the parser through random
// sender and receiver stalls and predicts every target and link-offline word
// in step. Covers reset settings, grammar errors, overlong packets, restarts
// and timeouts, then runs random packet traffic under several centre and
// timeout settings.
// ---------------------------------------------------------------------------
module tb;
  import tpp_pkg::*;

  localparam int PKT_LEN        = MAX_PACKET_LEN_DEF;
  localparam int WATCHDOG_LIMIT = 500;
  localparam int DRAIN_CYCLES   = 8;

  typedef struct packed {
    logic        cause;
    logic        tv;
    logic [15:0] tx;
    logic [15:0] ty;
    logic [15:0] ox;
    logic [15:0] oy;
  } target_rec_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [1:0]        cfg_index;
  logic [DATA_W-1:0] cfg_wdata;
  logic              sink_ready = 1'b0;
  int                sink_stall = 0;
  bit                idle_on = 1'b1;
  int                error_cnt = 0;
  int                result_cnt = 0;
  int                stall_watch = 0;
  int                items_sent = 0;
  target_rec_t       target_q[$];
  target_rec_t       head_rec;

  // predictor state
  logic [15:0] ctr_x;
  logic [15:0] ctr_y;
  logic [15:0] timeout_lim;
  logic        pkt_open;
  logic [4:0]  held_cnt;
  phase_t      pkt_phase;
  logic        gram_ok;
  logic        flag_bit;
  logic [15:0] acc_x;
  logic [15:0] acc_y;
  logic        link_up;
  logic [15:0] silence_ticks;

  tpp_in_if  in_ch ();
  tpp_out_if out_ch ();

  assign out_ch.ready = sink_ready;

  target_packet_parser u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_error(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_cnt++;
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want)
      report_error($sformatf("result %0d %s: got 0x%04h, expected 0x%04h",
                             result_cnt, name, got, want));
  endtask

  function automatic void predict_word(logic op, logic [7:0] b);
    target_rec_t rec;
    logic        is_digit;
    is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
    rec = '0;
    if (op == OP_TICK) begin
      if (silence_ticks != 16'hFFFF) silence_ticks++;
      if (link_up && silence_ticks > timeout_lim) begin
        link_up  = 1'b0;
        pkt_open = 1'b0;
        held_cnt = '0;
        rec.cause = CAUSE_OFFLINE;
        target_q.push_back(rec);
      end
    end else begin
      link_up       = 1'b1;
      silence_ticks = '0;
      if (b == CH_START) begin
        pkt_open  = 1'b1;
        held_cnt  = 5'd1;
        pkt_phase = PH_FLAG;
        gram_ok   = 1'b1;
        flag_bit  = 1'b0;
        acc_x     = '0;
        acc_y     = '0;
      end else if (pkt_open) begin
        if (held_cnt >= PKT_LEN - 1) begin
          pkt_open = 1'b0;
          held_cnt = '0;
        end else begin
          held_cnt++;
          if (b == CH_END) begin
            pkt_open = 1'b0;
            held_cnt = '0;
            if (gram_ok && pkt_phase == PH_Y) begin
              rec.cause = CAUSE_PACKET;
              rec.tv    = flag_bit;
              rec.tx    = acc_x;
              rec.ty    = acc_y;
              rec.ox    = acc_x - ctr_x;
              rec.oy    = acc_y - ctr_y;
              target_q.push_back(rec);
            end
          end else if (gram_ok) begin
            case (pkt_phase)
              PH_FLAG: begin
                if (b == CH_ZERO || b == CH_ONE) begin
                  flag_bit  = (b == CH_ONE);
                  pkt_phase = PH_SEP;
                end else gram_ok = 1'b0;
              end
              PH_SEP: begin
                if (b == CH_SEP) pkt_phase = PH_X0;
                else gram_ok = 1'b0;
              end
              PH_X0, PH_X: begin
                if (is_digit) begin
                  acc_x     = acc_x * 16'd10 + 16'(b - CH_ZERO);
                  pkt_phase = PH_X;
                end else if (pkt_phase == PH_X && b == CH_SEP) begin
                  pkt_phase = PH_Y0;
                end else gram_ok = 1'b0;
              end
              PH_Y0, PH_Y: begin
                if (is_digit) begin
                  acc_y     = acc_y * 16'd10 + 16'(b - CH_ZERO);
                  pkt_phase = PH_Y;
                end else gram_ok = 1'b0;
              end
              default: gram_ok = 1'b0;
            endcase
          end
        end
      end
    end
  endfunction

  task automatic send_word(logic op, logic [7:0] b);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.opcode  <= op;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_word(op, b);
    items_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_word(OP_BYTE, s[i]);
  endtask

  task automatic send_ticks(int n);
    for (int i = 0; i < n; i++) send_word(OP_TICK, 8'($urandom_range(0, 255)));
  endtask

  // hold the sender until every expected word has come out
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (target_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_CENTER_X: ctr_x = val;
      CFG_CENTER_Y: ctr_y = val;
      CFG_TIMEOUT:  timeout_lim = val;
      default: ;
    endcase
  endtask

  task automatic apply_settings(logic [15:0] cx, logic [15:0] cy, logic [15:0] tmo);
    settle();
    write_reg(CFG_CENTER_X, cx);
    write_reg(CFG_CENTER_Y, cy);
    write_reg(CFG_TIMEOUT, tmo);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_random_packet();
    logic [7:0] pkt[$];
    int         lx;
    int         ly;
    lx = $urandom_range(1, 5);
    ly = $urandom_range(1, 5);
    if ($urandom_range(0, 9) == 0) lx += $urandom_range(3, 6);
    pkt.push_back(CH_START);
    if ($urandom_range(0, 15) == 0) pkt.push_back(8'($urandom_range(0, 255)));
    else pkt.push_back(CH_ZERO + 8'($urandom_range(0, 1)));
    pkt.push_back(CH_SEP);
    repeat (lx) pkt.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    pkt.push_back(CH_SEP);
    repeat (ly) pkt.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    if ($urandom_range(0, 19) != 0) pkt.push_back(CH_END);
    if ($urandom_range(0, 7) == 0)
      pkt[$urandom_range(1, pkt.size() - 1)] = 8'($urandom_range(0, 255));
    foreach (pkt[i]) begin
      if ($urandom_range(0, 24) == 0) send_word(OP_TICK, 8'($urandom_range(0, 255)));
      send_word(OP_BYTE, pkt[i]);
    end
  endtask

  task automatic run_phase(logic [15:0] cx, logic [15:0] cy, logic [15:0] tmo, int n);
    int start;
    int burst;
    apply_settings(cx, cy, tmo);
    start = items_sent;
    while (items_sent - start < n) begin
      case ($urandom_range(0, 9))
        6, 7: begin
          burst = (tmo > 60) ? 64 : int'(tmo) + 3;
          send_ticks($urandom_range(1, burst));
        end
        8: repeat ($urandom_range(1, 3)) send_word(OP_BYTE, 8'($urandom_range(0, 255)));
        9: send_ticks(1);
        default: send_random_packet();
      endcase
    end
  endtask

  task automatic test_reset_settings();
    send_text("@1,200,120#");
    send_text("@0,0,0#");
    send_ticks(150);
    send_ticks(1);
    send_ticks(3);
  endtask

  task automatic test_packet_grammar();
    send_text("@0,65535,99999#");
    send_text("@1,12345,123456#");
    send_text("7#");
    send_text("@2,1,1#");
    send_text("@1;1,1#");
    send_text("@1,,1#");
    send_text("@1,1,#");
    send_text("@1,1#");
    send_text("@1,5,@0,7,8#");
    send_word(OP_BYTE, 8'h00);
    send_word(OP_BYTE, 8'hFF);
    send_text("@1,00012,0#");
  endtask

  task automatic test_link_timeout();
    apply_settings(16'd100, 16'd100, 16'd0);
    send_text("z");
    send_ticks(2);
    send_text("@1,3,");
    send_ticks(1);
    send_text("4#");
    send_text("@1,3,4#");
    apply_settings(16'hFFFF, 16'h0000, 16'd1);
    send_text("z");
    send_ticks(1);
    send_text("z");
    send_ticks(2);
    apply_settings(16'd0, 16'hFFFF, 16'hFFFF);
    idle_on <= 1'b0;
    send_text("@0,1,2#");
    send_ticks(300);
    send_text("@1,9,9#");
    idle_on <= 1'b1;
  endtask

  task automatic test_random_traffic();
    run_phase(16'd0, 16'hFFFF, 16'd3, 200);
    run_phase(16'hFFFF, 16'd0, 16'd0, 200);
    run_phase(16'($urandom), 16'($urandom), 16'($urandom_range(1, 40)), 200);
    run_phase(16'($urandom), 16'($urandom), 16'($urandom_range(5, 60)), 200);
    run_phase(16'd32768, 16'd32767, 16'd20, 200);
  endtask

  task automatic test_steady_stream();
    idle_on <= 1'b0;
    run_phase(16'($urandom), 16'($urandom), 16'($urandom_range(5, 30)), 200);
  endtask

  always @(posedge clk) begin
    if (sink_stall > 0) begin
      sink_stall <= sink_stall - 1;
      sink_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      sink_stall <= $urandom_range(0, 3);
      sink_ready <= 1'b0;
    end else begin
      sink_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid && out_ch.ready) begin
      if (target_q.size() == 0) begin
        report_error($sformatf("result %0d arrived with nothing expected", result_cnt));
      end else begin
        head_rec = target_q.pop_front();
        check_field("cause", 16'(out_ch.cause), 16'(head_rec.cause));
        check_field("target_valid", 16'(out_ch.target_valid), 16'(head_rec.tv));
        check_field("target_x", out_ch.target_x, head_rec.tx);
        check_field("target_y", out_ch.target_y, head_rec.ty);
        check_field("offset_x", out_ch.offset_x, head_rec.ox);
        check_field("offset_y", out_ch.offset_y, head_rec.oy);
      end
      result_cnt++;
    end
  end

  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_watch <= 0;
    end else if (stall_watch >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_watch <= stall_watch + 1;
    end
  end

  initial begin
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_CENTER_X;
    cfg_wdata     <= '0;
    in_ch.valid   <= 1'b0;
    in_ch.opcode  <= OP_BYTE;
    in_ch.rx_byte <= 8'h00;
    ctr_x         = 16'd200;
    ctr_y         = 16'd120;
    timeout_lim   = 16'd150;
    pkt_open      = 1'b0;
    held_cnt      = '0;
    pkt_phase     = PH_FLAG;
    gram_ok       = 1'b0;
    flag_bit      = 1'b0;
    acc_x         = '0;
    acc_y         = '0;
    link_up       = 1'b0;
    silence_ticks = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    test_reset_settings();
    test_packet_grammar();
    test_link_timeout();
    test_random_traffic();
    test_steady_stream();

    settle();
    if (target_q.size() != 0)
      report_error($sformatf("%0d expected results never arrived", target_q.size()));
    if (error_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
